/* rtl/sop_pkg.sv */
// Shared types and constants for the sphere overlap placement unit.
// No dependencies; imported by the placement unit, the overlap test and the testbench.
`default_nettype none

package sop_pkg;

    localparam int COORD_W  = 20;
    localparam int RADIUS_W = 16;
    localparam int TRIALS_W = 20;
    localparam int COUNT_W  = 13;
    localparam int TOTAL_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int D2_W   = SQ_W + 2;
    localparam int RSUM_W = RADIUS_W + 1;
    localparam int RSQ_W  = 2 * RSUM_W;

    localparam logic [TRIALS_W-1:0] TRIALS_MAX   = '1;
    localparam logic [TRIALS_W-1:0] TRIALS_RESET = 20'd120000;
    localparam logic [COUNT_W-1:0]  TARGET_RESET = 13'd4000;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIALS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 2'd1;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_REJECTED = 2'd1,
        ST_GAVE_UP  = 2'd2,
        ST_FINISHED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
        logic        [RADIUS_W-1:0] r;
    } t_sphere;

    localparam int SPH_W = $bits(t_sphere);

    // Status of the overlap test pipeline as seen by the controller.
    typedef struct packed {
        logic busy;
        logic hit_vld;
        logic hit;
    } t_scan_status;

endpackage

`default_nettype wire

/* rtl/sphere_overlap_placement_unit.sv */
// Sphere overlap placement: tests a candidate against every stored sphere.
// The o_valid strobe follows one read per stored sphere, a drain of the overlap test and
// a decide state; an empty store goes straight to decide, and a finished unit strobes from idle.
// busy falls with the strobe, which sets the item spacing; results cannot be held off.
// Reset (synchronous, active low) clears the counts and restores the
// register defaults; the sphere memory is not cleared and needs no pass.
`default_nettype none

module sphere_overlap_placement_unit #(
    parameter int CAPACITY = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output      logic                            busy,
    input  wire logic signed [sop_pkg::COORD_W-1:0]  i_cand_x,
    input  wire logic signed [sop_pkg::COORD_W-1:0]  i_cand_y,
    input  wire logic signed [sop_pkg::COORD_W-1:0]  i_cand_z,
    input  wire logic        [sop_pkg::RADIUS_W-1:0] i_cand_radius,
    output      logic                            o_valid,
    output      logic [1:0]                      o_status,
    output      logic [sop_pkg::COUNT_W-1:0]     o_placed_count,
    output      logic [sop_pkg::TRIALS_W-1:0]    o_sphere_trials,
    output      logic [sop_pkg::TOTAL_W-1:0]     o_total_trials,
    input  wire logic                            i_cfg_valid,
    output      logic                            o_cfg_ready,
    input  wire logic [sop_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sop_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sop_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;

    t_state               r_state, n_state;
    t_sphere              r_cand;
    logic [AW-1:0]        r_addr;
    logic                 r_rd_vld;
    logic                 r_hit;
    logic [CW-1:0]        r_count;
    logic [TRIALS_W-1:0]  r_trials;
    logic [TOTAL_W-1:0]   r_total;
    logic                 r_finished;
    logic [TRIALS_W-1:0]  r_max_trials;
    logic [COUNT_W-1:0]   r_target;
    t_status              r_status;

    logic                 accept;
    logic                 full_now;
    logic                 full_next;
    logic                 scan_last;
    logic                 rd_en;
    logic                 wr_en;
    logic [CW-1:0]        count_inc;
    logic [TRIALS_W-1:0]  trials_inc;
    logic [TOTAL_W:0]     total_sum;
    logic [SPH_W-1:0]     rd_data;
    t_sphere              cand_in;
    t_scan_status         scan;

    assign cand_in.x = i_cand_x;
    assign cand_in.y = i_cand_y;
    assign cand_in.z = i_cand_z;
    assign cand_in.r = i_cand_radius;

    assign accept     = start && !busy;
    assign count_inc  = r_count + CW'(1);
    assign full_now   = (WW'(r_count) >= WW'(r_target)) || (r_count == CW'(CAPACITY));
    assign full_next  = (WW'(count_inc) >= WW'(r_target)) || (count_inc == CW'(CAPACITY));
    assign scan_last  = (CW'(r_addr) + CW'(1) == r_count);
    assign trials_inc = (r_trials == TRIALS_MAX) ? r_trials : r_trials + TRIALS_W'(1);
    assign total_sum  = {1'b0, r_total} + (TOTAL_W + 1)'(r_trials);

    sop_sphere_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (SPH_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (r_cand),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    sop_overlap_test u_test (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rd_vld),
        .i_entry  (rd_data),
        .i_cand   (r_cand),
        .o_status (scan)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && !(r_finished || full_now)) begin
                    n_state = (r_count == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !scan.busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy  = 1'b1;
        rd_en = 1'b0;
        wr_en = 1'b0;
        case (r_state)
            S_IDLE:   busy  = 1'b0;
            S_SCAN:   rd_en = 1'b1;
            S_DRAIN:  ;
            S_DECIDE: wr_en = !r_hit;
            default:  ;
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_vld     <= 1'b0;
            r_count      <= '0;
            r_trials     <= TRIALS_W'(1);
            r_total      <= '0;
            r_finished   <= 1'b0;
            r_max_trials <= TRIALS_RESET;
            r_target     <= TARGET_RESET;
            o_valid      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            o_valid  <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_TRIALS:   r_max_trials <= i_cfg_data[TRIALS_W-1:0];
                    REG_TARGET_COUNT: r_target     <= i_cfg_data[COUNT_W-1:0];
                    default:          ;
                endcase
            end

            if (accept && (r_finished || full_now)) begin
                // Finished, the store is full, or the target has been reached or lowered.
                r_finished <= 1'b1;
                o_valid    <= 1'b1;
            end

            if (r_state == S_DECIDE) begin
                o_valid <= 1'b1;
                if (r_hit) begin
                    r_trials <= trials_inc;
                    if (trials_inc >= r_max_trials) begin
                        r_finished <= 1'b1;
                    end
                end else begin
                    r_count  <= count_inc;
                    r_total  <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                    r_trials <= TRIALS_W'(1);
                    if (full_next) begin
                        r_finished <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cand <= cand_in;
            r_hit  <= 1'b0;
        end else if (scan.hit_vld && scan.hit) begin
            r_hit  <= 1'b1;
        end

        if (r_state == S_SCAN) begin
            r_addr <= r_addr + AW'(1);
        end else begin
            r_addr <= '0;
        end

        if (accept && (r_finished || full_now)) begin
            r_status <= ST_FINISHED;
        end else if (r_state == S_DECIDE) begin
            if (!r_hit) begin
                r_status <= ST_ACCEPTED;
            end else if (trials_inc >= r_max_trials) begin
                r_status <= ST_GAVE_UP;
            end else begin
                r_status <= ST_REJECTED;
            end
        end
    end

    // Result fields report the counters as they stand once the item is done.
    assign o_status        = r_status;
    assign o_placed_count  = COUNT_W'(r_count);
    assign o_sphere_trials = r_trials;
    assign o_total_trials  = r_total;

endmodule

`default_nettype wire

/* rtl/sop_sphere_mem.sv */
// Sphere store: single write port, single read port, registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module sop_sphere_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 76
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/sop_overlap_test.sv */
// Three-stage overlap test of one stored sphere against the candidate.
// Depends on sop_pkg for the sphere and status types.
`default_nettype none

module sop_overlap_test (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [sop_pkg::SPH_W-1:0] i_entry,
    input  wire sop_pkg::t_sphere        i_cand,
    output      sop_pkg::t_scan_status   o_status
);
    import sop_pkg::*;

    t_sphere entry;
    assign entry = t_sphere'(i_entry);

    logic                     r_vld_a, r_vld_b, r_vld_c;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic        [RSUM_W-1:0] r_rsum;
    logic        [SQ_W-1:0]   r_qx, r_qy, r_qz;
    logic        [RSQ_W-1:0]  r_rsq;
    logic                     r_hit;

    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic signed [SQ_W-1:0]   qx, qy, qz;
    logic        [D2_W-1:0]   d2;

    assign dx = {entry.x[COORD_W-1], entry.x} - {i_cand.x[COORD_W-1], i_cand.x};
    assign dy = {entry.y[COORD_W-1], entry.y} - {i_cand.y[COORD_W-1], i_cand.y};
    assign dz = {entry.z[COORD_W-1], entry.z} - {i_cand.z[COORD_W-1], i_cand.z};
    assign qx = r_dx * r_dx;
    assign qy = r_dy * r_dy;
    assign qz = r_dz * r_dz;
    assign d2 = D2_W'(r_qx) + D2_W'(r_qy) + D2_W'(r_qz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= dx;
        r_dy   <= dy;
        r_dz   <= dz;
        r_rsum <= {1'b0, entry.r} + {1'b0, i_cand.r};
        r_qx   <= SQ_W'(unsigned'(qx));
        r_qy   <= SQ_W'(unsigned'(qy));
        r_qz   <= SQ_W'(unsigned'(qz));
        r_rsq  <= r_rsum * r_rsum;
        // Touching spheres count as overlapping.
        r_hit  <= (d2 <= D2_W'(r_rsq));
    end

    assign o_status.busy    = r_vld_a | r_vld_b | r_vld_c;
    assign o_status.hit_vld = r_vld_c;
    assign o_status.hit     = r_hit;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sphere_overlap_placement_unit: directed and random candidate
// spheres, register writes between phases, and a scoreboard fed by an in-bench predictor.
// Depends on sop_pkg and the unit's RTL only.

module tb_top;
    import sop_pkg::*;

    localparam int CAPACITY = 4096;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int BOX      = 1 << 17;

    typedef struct packed {
        t_status             status;
        logic [COUNT_W-1:0]  placed;
        logic [TRIALS_W-1:0] trials;
        logic [TOTAL_W-1:0]  total;
    } t_verdict;

    typedef enum {
        END_GIVE_UP,
        END_TARGET_LOWERED,
        END_TARGET_MET
    } t_ending;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [COORD_W-1:0]     i_cand_x = '0;
    logic signed [COORD_W-1:0]     i_cand_y = '0;
    logic signed [COORD_W-1:0]     i_cand_z = '0;
    logic        [RADIUS_W-1:0]    i_cand_radius = '0;
    logic                          o_valid;
    logic [1:0]                    o_status;
    logic [COUNT_W-1:0]            o_placed_count;
    logic [TRIALS_W-1:0]           o_sphere_trials;
    logic [TOTAL_W-1:0]            o_total_trials;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = REG_MAX_TRIALS;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;

    // Predicted state of the placement core.
    t_sphere               placed_sph [CAPACITY];
    logic [COUNT_W-1:0]    n_placed = '0;
    logic [TRIALS_W-1:0]   cur_trials = TRIALS_W'(1);
    logic [TOTAL_W-1:0]    trial_sum = '0;
    bit                    placement_done = 1'b0;
    logic [TRIALS_W-1:0]   lim_trials = TRIALS_RESET;
    logic [COUNT_W-1:0]    lim_target = TARGET_RESET;

    t_sphere  candidate_q [$];
    t_verdict verdict_q [$];
    int       gap_pct = 31;
    bit       cand_taken = 1'b0;
    int       mismatch_count = 0;

    sphere_overlap_placement_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cand_x        (i_cand_x),
        .i_cand_y        (i_cand_y),
        .i_cand_z        (i_cand_z),
        .i_cand_radius   (i_cand_radius),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_placed_count  (o_placed_count),
        .o_sphere_trials (o_sphere_trials),
        .o_total_trials  (o_total_trials),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Touching counts as overlap; all terms are exact in 64 bits.
    function automatic bit overlaps(t_sphere a, t_sphere b);
        longint dx, dy, dz, rs;
        dx = longint'($signed(a.x)) - longint'($signed(b.x));
        dy = longint'($signed(a.y)) - longint'($signed(b.y));
        dz = longint'($signed(a.z)) - longint'($signed(b.z));
        rs = longint'(a.r) + longint'(b.r);
        return dx * dx + dy * dy + dz * dz <= rs * rs;
    endfunction

    function automatic t_verdict judge_candidate(t_sphere c);
        t_verdict           v;
        bit                 hit;
        int                 k;
        logic [TOTAL_W:0]   wide_sum;
        hit = 1'b0;
        if (n_placed >= lim_target || n_placed >= CAPACITY)
            placement_done = 1'b1;
        if (placement_done) begin
            v.status = ST_FINISHED;
        end else begin
            for (k = 0; k < n_placed; k++)
                if (overlaps(c, placed_sph[k[IDX_W-1:0]]))
                    hit = 1'b1;
            if (hit) begin
                if (cur_trials != TRIALS_MAX)
                    cur_trials++;
                if (cur_trials >= lim_trials) begin
                    placement_done = 1'b1;
                    v.status = ST_GAVE_UP;
                end else begin
                    v.status = ST_REJECTED;
                end
            end else begin
                placed_sph[n_placed[IDX_W-1:0]] = c;
                n_placed++;
                wide_sum = trial_sum + cur_trials;
                trial_sum = wide_sum[TOTAL_W] ? '1 : wide_sum[TOTAL_W-1:0];
                cur_trials = TRIALS_W'(1);
                if (n_placed >= lim_target || n_placed >= CAPACITY)
                    placement_done = 1'b1;
                v.status = ST_ACCEPTED;
            end
        end
        v.placed = n_placed;
        v.trials = cur_trials;
        v.total  = trial_sum;
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] nudge(logic signed [COORD_W-1:0] v, int off);
        longint t;
        t = longint'(v) + off;
        if (t > 524287)
            t = longint'(v) - off;
        return t[COORD_W-1:0];
    endfunction

    // Mostly spheres in a central box or set against a stored sphere at, just inside, well inside or
    // just beyond contact; the rest is noise over the full field ranges.
    function automatic t_sphere make_candidate();
        t_sphere c;
        t_sphere base;
        int      pick;
        int      off;
        pick = $urandom_range(99);
        if (pick < 15) begin
            c.x = COORD_W'($urandom);
            c.y = COORD_W'($urandom);
            c.z = COORD_W'($urandom);
            c.r = RADIUS_W'($urandom);
        end else if (pick < 50 && n_placed != 0) begin
            base = placed_sph[IDX_W'($urandom_range(n_placed - 1))];
            c = base;
            c.r = RADIUS_W'($urandom_range(4095));
            off = int'(base.r) + int'(c.r) + int'($urandom_range(2)) - 1;
            if (pick < 22)
                off = $urandom_range(off < 0 ? 0 : off);
            case ($urandom_range(2))
                0: c.x = nudge(base.x, off);
                1: c.y = nudge(base.y, off);
                default: c.z = nudge(base.z, off);
            endcase
        end else begin
            c.x = COORD_W'(int'($urandom_range(2 * BOX)) - BOX);
            c.y = COORD_W'(int'($urandom_range(2 * BOX)) - BOX);
            c.z = COORD_W'(int'($urandom_range(2 * BOX)) - BOX);
            c.r = RADIUS_W'($urandom_range($urandom_range(1) ? 16383 : 1023));
        end
        return c;
    endfunction

    // Driver: a new candidate goes out once the previous one has been transferred.
    always @(negedge i_clk) begin
        t_sphere nxt;
        if (i_rst_n && (cand_taken || !start) && candidate_q.size() != 0
            && $urandom_range(99) >= gap_pct && (!busy || $urandom_range(1))) begin
            nxt = candidate_q.pop_front();
            i_cand_x      <= nxt.x;
            i_cand_y      <= nxt.y;
            i_cand_z      <= nxt.z;
            i_cand_radius <= nxt.r;
            start         <= 1'b1;
        end else if (cand_taken || !i_rst_n) begin
            start <= 1'b0;
        end
    end

    // Monitor: checks each result strobe, then predicts for any candidate transfer.
    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        t_sphere  c;
        cand_taken <= i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            got.status = t_status'(o_status);
            got.placed = o_placed_count;
            got.trials = o_sphere_trials;
            got.total  = o_total_trials;
            if (verdict_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: status %0d placed %0d trials %0d total %0d",
                         $time, got.status, got.placed, got.trials, got.total);
            end else begin
                want = verdict_q.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    $display("%0t: mismatch: expected status %0d placed %0d trials %0d total %0d",
                             $time, want.status, want.placed, want.trials, want.total);
                    $display("%0t:           actual   status %0d placed %0d trials %0d total %0d",
                             $time, got.status, got.placed, got.trials, got.total);
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            c.x = i_cand_x;
            c.y = i_cand_y;
            c.z = i_cand_z;
            c.r = i_cand_radius;
            verdict_q.insert(verdict_q.size(), judge_candidate(c));
        end
    end

    task automatic add_candidate(t_sphere c);
        candidate_q.insert(candidate_q.size(), c);
    endtask

    task automatic queue_sphere(int x, int y, int z, int r);
        t_sphere c;
        c.x = x[COORD_W-1:0];
        c.y = y[COORD_W-1:0];
        c.z = z[COORD_W-1:0];
        c.r = r[RADIUS_W-1:0];
        add_candidate(c);
    endtask

    task automatic settle();
        while (candidate_q.size() != 0 || start || verdict_q.size() != 0 || busy)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == REG_MAX_TRIALS)
            lim_trials = data[TRIALS_W-1:0];
        else if (idx == REG_TARGET_COUNT)
            lim_target = data[COUNT_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(int trials, int target);
        write_reg(REG_MAX_TRIALS, trials);
        write_reg(REG_TARGET_COUNT, target);
    endtask

    initial begin
        t_sphere c;
        t_ending ending;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed candidates under the reset register values.
        queue_sphere(-524288, -524288, -524288, 0);
        queue_sphere(524287, 524287, 524287, 65535);
        queue_sphere(-524288, -524288, -524288, 0);
        queue_sphere(458652, 524287, 524287, 100);
        queue_sphere(458651, 524287, 524287, 100);
        queue_sphere(0, 0, 0, 1000);
        queue_sphere(2000, 0, 0, 1000);
        queue_sphere(0, -2001, 0, 1000);
        queue_sphere(0, 0, 2000, 999);
        queue_sphere(1, 1, 1, 65535);
        repeat (3) queue_sphere(0, 0, 0, 0);
        queue_sphere(-524288, 524287, -524288, 65535);
        queue_sphere(524287, -524288, 524287, 0);
        settle();

        for (int p = 0; p < 7; p++) begin
            gap_pct = (p < 3) ? 31 : (p < 5) ? 82 : 0;
            // Limits always stay clear of what one phase of 17 candidates can reach.
            case (p)
                0: set_limits(-1, -1);
                1: set_limits(cur_trials + 21, 4096);
                2: set_limits($urandom_range(32'hFFFFF, cur_trials + 21), n_placed + 21);
                3: set_limits(TRIALS_RESET, $urandom_range(8191, n_placed + 21));
                4: set_limits(cur_trials + 21, n_placed + 21);
                5: set_limits(-1, 4096);
                default: set_limits($urandom_range(32'hFFFFF, cur_trials + 21),
                                    $urandom_range(8191, n_placed + 21));
            endcase
            repeat (17) add_candidate(make_candidate());
            settle();
        end

        // Finishing is permanent, so only one way of ending is taken per run.
        gap_pct = 31;
        ending = t_ending'($urandom_range(2));
        case (ending)
            END_GIVE_UP: begin
                write_reg(REG_MAX_TRIALS, $urandom_range(1));
                add_candidate(placed_sph[IDX_W'($urandom_range(n_placed - 1))]);
                repeat (3) add_candidate(make_candidate());
            end
            END_TARGET_LOWERED: begin
                write_reg(REG_TARGET_COUNT, $urandom_range(1) ? 0 : n_placed);
                repeat (4) add_candidate(make_candidate());
            end
            default: begin
                write_reg(REG_TARGET_COUNT, n_placed + 1);
                repeat (8) begin
                    c.x = COORD_W'($urandom);
                    c.y = COORD_W'($urandom);
                    c.z = COORD_W'($urandom);
                    c.r = '0;
                    add_candidate(c);
                end
            end
        endcase
        settle();
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0 && verdict_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/sop_pkg.sv
rtl/sop_sphere_mem.sv
rtl/sop_overlap_test.sv
rtl/sphere_overlap_placement_unit.sv
sim/tb_top.sv
